>>> rtl/core/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared request codes, status codes and default sizes for the cursor list.
// ----------------------------------------------------------------------------
package cdll_pkg;

  localparam int unsigned DEF_POOL_NODES = 256;
  localparam int unsigned DEF_VALUE_BITS = 32;

  typedef enum logic [4:0] {
    REQ_CLEAR      = 5'd0,
    REQ_INS_FIRST  = 5'd1,
    REQ_INS_LAST   = 5'd2,
    REQ_FIRST      = 5'd3,
    REQ_LAST       = 5'd4,
    REQ_GET_FIRST  = 5'd5,
    REQ_GET_LAST   = 5'd6,
    REQ_DEL_FIRST  = 5'd7,
    REQ_DEL_LAST   = 5'd8,
    REQ_DEL_AFTER  = 5'd9,
    REQ_DEL_BEFORE = 5'd10,
    REQ_INS_AFTER  = 5'd11,
    REQ_INS_BEFORE = 5'd12,
    REQ_GET        = 5'd13,
    REQ_SET        = 5'd14,
    REQ_NEXT       = 5'd15,
    REQ_PREV       = 5'd16,
    REQ_IS_ACTIVE  = 5'd17
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

>>> rtl/core/cursor_doubly_linked_list.sv
// Paths: moves, reads, flag queries, clear and failed requests read one node
//   and answer; set adds a value write; end inserts and deletes, and inserts
//   beside the cursor from fresh nodes, plan and write links; others read two nodes.
// Throughput: one beat at a time; the next beat is taken the cycle after the
//   result beat leaves.
// Reset: list, cursor and free list empty, allocator at zero; memories kept.
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list
// Doubly linked list with head, tail and cursor over a node pool held in
// value, forward-link and backward-link memories with a free list.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list
  import cdll_pkg::*;
#(
  parameter int unsigned POOL_NODES = DEF_POOL_NODES,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  req_type,
  input  logic [31:0] item_value,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic        cursor_active,
  output logic        list_empty,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam int unsigned IW = $clog2(POOL_NODES + 1);
  localparam int unsigned AW = $clog2(POOL_NODES);
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD_A  = 8'b0000_0010,
    S_DAT_A = 8'b0000_0100,
    S_RD_B  = 8'b0000_1000,
    S_DAT_B = 8'b0001_0000,
    S_PLAN  = 8'b0010_0000,
    S_WR_1  = 8'b0100_0000,
    S_WR_2  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t dat_state_next;
  logic   out_pend;

  logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
  logic [IW-1:0]         fwd_mem [POOL_NODES];
  logic [IW-1:0]         bwd_mem [POOL_NODES];

  logic [VALUE_BITS-1:0] r_v;
  logic [IW-1:0]         r_f, r_b;
  logic [AW-1:0]         rd_addr;

  logic [4:0]            req;
  logic [VALUE_BITS-1:0] val;
  logic [IW-1:0]         head, tail, cur, fhead, fresh;
  logic [IW-1:0]         n, p, q;
  logic [31:0]           rd;
  logic [1:0]            st;

  logic                  f0_en, f1_en, b0_en, b1_en, v_en;
  logic [IW-1:0]         f0_a, f0_d, f1_a, f1_d, b0_a, b0_d, b1_a, b1_d, v_a;

  logic                  f_we, b_we, v_we;
  logic [AW-1:0]         f_wa, b_wa;
  logic [IW-1:0]         f_wd, b_wd;
  logic [IW-1:0]         addr_a;
  logic                  is_ins;

  assign in_stall      = (state != S_IDLE) || out_pend;
  assign out_valid     = out_pend;
  assign read_value    = rd;
  assign status        = st;
  assign cursor_active = (cur != NIL);
  assign list_empty    = (head == NIL);

  assign is_ins = (req == REQ_INS_FIRST) || (req == REQ_INS_LAST) ||
                  (req == REQ_INS_AFTER) || (req == REQ_INS_BEFORE);

  always_comb begin
    case (req)
      REQ_INS_FIRST, REQ_INS_LAST:   addr_a = fhead;
      REQ_GET_FIRST, REQ_DEL_FIRST:  addr_a = head;
      REQ_GET_LAST, REQ_DEL_LAST:    addr_a = tail;
      default:                       addr_a = cur;
    endcase
    rd_addr = (state == S_RD_B) ? (is_ins ? fhead[AW-1:0] : n[AW-1:0]) : addr_a[AW-1:0];
  end

  always_comb begin
    case (req)
      REQ_SET:                     dat_state_next = (cur != NIL) ? S_WR_1 : S_IDLE;
      REQ_DEL_FIRST, REQ_DEL_LAST: dat_state_next = (addr_a != NIL) ? S_PLAN : S_IDLE;
      REQ_DEL_AFTER:  dat_state_next = (cur != NIL && r_f != NIL) ? S_RD_B : S_IDLE;
      REQ_DEL_BEFORE: dat_state_next = (cur != NIL && r_b != NIL) ? S_RD_B : S_IDLE;
      REQ_INS_FIRST, REQ_INS_LAST: begin
        dat_state_next = (fhead != NIL || fresh != NIL) ? S_PLAN : S_IDLE;
      end
      REQ_INS_AFTER, REQ_INS_BEFORE: begin
        if (cur == NIL) dat_state_next = S_IDLE;
        else if (fhead != NIL) dat_state_next = S_RD_B;
        else if (fresh != NIL) dat_state_next = S_PLAN;
        else dat_state_next = S_IDLE;
      end
      default: dat_state_next = S_IDLE;
    endcase
  end

  always_comb begin
    f_we = ((state == S_WR_1) && f0_en) || ((state == S_WR_2) && f1_en);
    b_we = ((state == S_WR_1) && b0_en) || ((state == S_WR_2) && b1_en);
    v_we = (state == S_WR_1) && v_en;
    f_wa = (state == S_WR_1) ? f0_a[AW-1:0] : f1_a[AW-1:0];
    f_wd = (state == S_WR_1) ? f0_d : f1_d;
    b_wa = (state == S_WR_1) ? b0_a[AW-1:0] : b1_a[AW-1:0];
    b_wd = (state == S_WR_1) ? b0_d : b1_d;
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fwd_mem[f_wa] <= f_wd;
    end
    if (b_we) begin
      bwd_mem[b_wa] <= b_wd;
    end
    if (v_we) begin
      val_mem[v_a[AW-1:0]] <= val;
    end
    r_v <= val_mem[rd_addr];
    r_f <= fwd_mem[rd_addr];
    r_b <= bwd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_pend <= 1'b0;
      head     <= NIL;
      tail     <= NIL;
      cur      <= NIL;
      fhead    <= NIL;
      fresh    <= '0;
      f0_en    <= 1'b0;
      f1_en    <= 1'b0;
      b0_en    <= 1'b0;
      b1_en    <= 1'b0;
      v_en     <= 1'b0;
    end else begin
      if (out_pend && !out_stall) begin
        out_pend <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req   <= req_type;
            val   <= VALUE_BITS'(item_value);
            rd    <= '0;
            st    <= ST_OK;
            f0_en <= 1'b0;
            f1_en <= 1'b0;
            b0_en <= 1'b0;
            b1_en <= 1'b0;
            v_en  <= 1'b0;
            state <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_DAT_A;
        end
        S_DAT_A: begin
          state    <= dat_state_next;
          out_pend <= (dat_state_next == S_IDLE);
          case (req)
            REQ_CLEAR: begin
              head  <= NIL;
              tail  <= NIL;
              cur   <= NIL;
              fhead <= NIL;
              fresh <= '0;
            end
            REQ_FIRST: cur <= head;
            REQ_LAST:  cur <= tail;
            REQ_GET_FIRST, REQ_GET_LAST, REQ_GET: begin
              if (addr_a != NIL) begin
                rd <= 32'(r_v);
              end else begin
                st <= ST_EMPTY;
              end
            end
            REQ_SET: begin
              if (cur != NIL) begin
                v_en <= 1'b1;
                v_a  <= cur;
              end
            end
            REQ_NEXT: if (cur != NIL) cur <= r_f;
            REQ_PREV: if (cur != NIL) cur <= r_b;
            REQ_DEL_FIRST, REQ_DEL_LAST: begin
              if (addr_a != NIL) begin
                n <= addr_a;
                p <= r_b;
                q <= r_f;
              end
            end
            REQ_DEL_AFTER: begin
              if (cur != NIL && r_f != NIL) begin
                n <= r_f;
              end
            end
            REQ_DEL_BEFORE: begin
              if (cur != NIL && r_b != NIL) begin
                n <= r_b;
              end
            end
            REQ_INS_FIRST, REQ_INS_LAST: begin
              p <= (req == REQ_INS_LAST) ? tail : NIL;
              q <= (req == REQ_INS_FIRST) ? head : NIL;
              if (fhead != NIL) begin
                n     <= fhead;
                fhead <= r_f;
              end else if (fresh != NIL) begin
                n     <= fresh;
                fresh <= fresh + IW'(1);
              end else begin
                st <= ST_FULL;
              end
            end
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
              if (cur != NIL) begin
                p <= (req == REQ_INS_AFTER) ? cur : r_b;
                q <= (req == REQ_INS_AFTER) ? r_f : cur;
                if (fhead == NIL) begin
                  if (fresh != NIL) begin
                    n     <= fresh;
                    fresh <= fresh + IW'(1);
                  end else begin
                    st <= ST_FULL;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_RD_B: begin
          state <= S_DAT_B;
        end
        S_DAT_B: begin
          if (is_ins) begin
            n     <= fhead;
            fhead <= r_f;
          end else begin
            p <= r_b;
            q <= r_f;
          end
          state <= S_PLAN;
        end
        S_PLAN: begin
          if (is_ins) begin
            v_en  <= 1'b1;
            v_a   <= n;
            b0_en <= 1'b1;
            b0_a  <= n;
            b0_d  <= p;
            f0_en <= 1'b1;
            f0_a  <= n;
            f0_d  <= q;
            f1_en <= (p != NIL);
            f1_a  <= p;
            f1_d  <= n;
            b1_en <= (q != NIL);
            b1_a  <= q;
            b1_d  <= n;
            if (p == NIL) head <= n;
            if (q == NIL) tail <= n;
          end else begin
            f0_en <= (p != NIL);
            f0_a  <= p;
            f0_d  <= q;
            b0_en <= (q != NIL);
            b0_a  <= q;
            b0_d  <= p;
            f1_en <= 1'b1;
            f1_a  <= n;
            f1_d  <= fhead;
            fhead <= n;
            if (n == cur) cur <= NIL;
            if (p == NIL) head <= q;
            if (q == NIL) tail <= p;
          end
          state <= S_WR_1;
        end
        S_WR_1: begin
          state <= S_WR_2;
        end
        S_WR_2: begin
          out_pend <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/cdll_checker.sv
// ----------------------------------------------------------------------------
// cdll_checker
// Port-level checks of the cursor list, bound to the list module.
// ----------------------------------------------------------------------------
module cdll_checker
  import cdll_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] read_value,
  input logic [1:0]  status,
  input logic        cursor_active,
  input logic        list_empty,
  input logic        out_valid,
  input logic        out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_value == 32'd0)
    else $error("error beat carries a value");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || cursor_active) |-> !list_empty)
    else $error("full pool or live cursor on empty list");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

endmodule

bind cursor_doubly_linked_list cdll_checker u_cdll_checker (.*);
